### sv/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, codes and helpers for the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int unsigned TickW = 16;
  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_DEBOUNCE      = 3'd0,
    REG_LONG_PRESS    = 3'd1,
    REG_CLICK_RELEASE = 3'd2,
    REG_RELEASE_QUIET = 3'd3,
    REG_HOLD          = 3'd4,
    REG_RESET         = 3'd5
  } reg_index_t;

  // reset values of the registers
  localparam logic [TickW-1:0] DebounceInit     = 16'd10;
  localparam logic [TickW-1:0] LongPressInit    = 16'd3000;
  localparam logic [TickW-1:0] ClickReleaseInit = 16'd200;
  localparam logic [TickW-1:0] ReleaseQuietInit = 16'd100;
  localparam logic [TickW-1:0] HoldInit         = 16'd6000;
  localparam logic [TickW-1:0] ResetInit        = 16'd10000;

  // gesture codes on the result
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_CLICK        = 3'd1,
    EV_DOUBLE_CLICK = 3'd2,
    EV_LONG_PRESS   = 3'd3,
    EV_HOLD         = 3'd4
  } event_t;

  // classifier phases
  typedef enum logic [2:0] {
    PH_WAIT_RELEASE = 3'd0,
    PH_ARMED        = 3'd1,
    PH_DEBOUNCE     = 3'd2,
    PH_PRESS        = 3'd3,
    PH_CLICK_WAIT   = 3'd4,
    PH_SECOND_PRESS = 3'd5,
    PH_SECOND_REL   = 3'd6,
    PH_LONG_WAIT    = 3'd7
  } phase_t;

  // thresholds as seen by the classifier
  typedef struct packed {
    logic [TickW-1:0] debounce_ticks;
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] click_release_ticks;
    logic [TickW-1:0] release_quiet_ticks;
    logic [TickW-1:0] hold_ticks;
    logic [TickW-1:0] reset_ticks;
  } cfg_t;

  // saturating tick increment
  function automatic logic [TickW-1:0] tick_inc(input logic [TickW-1:0] v);
    tick_inc = (v == TickMax) ? TickMax : v + 1'b1;
  endfunction

endpackage

### sv/bgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module bgc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [2:0]                  wr_index,
  input  logic [bgc_pkg::TickW-1:0]   wr_data,
  output bgc_pkg::cfg_t               cfg
);

  bgc_pkg::cfg_t regs;

  // decode the index, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ticks      <= bgc_pkg::DebounceInit;
      regs.long_press_ticks    <= bgc_pkg::LongPressInit;
      regs.click_release_ticks <= bgc_pkg::ClickReleaseInit;
      regs.release_quiet_ticks <= bgc_pkg::ReleaseQuietInit;
      regs.hold_ticks          <= bgc_pkg::HoldInit;
      regs.reset_ticks         <= bgc_pkg::ResetInit;
    end else if (wr_en) begin
      unique case (wr_index)
        bgc_pkg::REG_DEBOUNCE:      regs.debounce_ticks      <= wr_data;
        bgc_pkg::REG_LONG_PRESS:    regs.long_press_ticks    <= wr_data;
        bgc_pkg::REG_CLICK_RELEASE: regs.click_release_ticks <= wr_data;
        bgc_pkg::REG_RELEASE_QUIET: regs.release_quiet_ticks <= wr_data;
        bgc_pkg::REG_HOLD:          regs.hold_ticks          <= wr_data;
        bgc_pkg::REG_RESET:         regs.reset_ticks         <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### sv/bgc_fsm.sv
// ----------------------------------------------------------------------------
// bgc_fsm
// Gesture state machine with saturating press and release timers.
// ----------------------------------------------------------------------------
module bgc_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  key_down,
  input  logic                  display_on,
  input  bgc_pkg::cfg_t         cfg,
  output bgc_pkg::event_t       event_code,
  output logic                  reset_request
);

  bgc_pkg::phase_t             phase, phase_next;
  logic [bgc_pkg::TickW-1:0]   press_ticks, press_ticks_next;
  logic [bgc_pkg::TickW-1:0]   release_ticks, release_ticks_next;
  logic [bgc_pkg::TickW-1:0]   press_inc, release_inc;
  bgc_pkg::event_t             ev;

  assign press_inc   = bgc_pkg::tick_inc(press_ticks);
  assign release_inc = bgc_pkg::tick_inc(release_ticks);

  // state registers, advanced once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bgc_pkg::PH_WAIT_RELEASE;
      press_ticks   <= '0;
      release_ticks <= '0;
    end else if (step) begin
      phase         <= phase_next;
      press_ticks   <= press_ticks_next;
      release_ticks <= release_ticks_next;
    end
  end

  // next state and gesture for the current item
  always_comb begin
    phase_next         = phase;
    press_ticks_next   = press_ticks;
    release_ticks_next = release_ticks;
    ev                 = bgc_pkg::EV_NONE;
    reset_request      = 1'b0;
    unique case (phase)
      bgc_pkg::PH_WAIT_RELEASE: begin
        if (!key_down) phase_next = bgc_pkg::PH_ARMED;
      end
      bgc_pkg::PH_ARMED: begin
        if (key_down) begin
          phase_next       = bgc_pkg::PH_DEBOUNCE;
          press_ticks_next = '0;
        end
      end
      bgc_pkg::PH_DEBOUNCE: begin
        press_ticks_next = press_inc;
        if (!key_down) phase_next = bgc_pkg::PH_WAIT_RELEASE;
        else if (press_inc > cfg.debounce_ticks) phase_next = bgc_pkg::PH_PRESS;
      end
      bgc_pkg::PH_PRESS: begin
        if (key_down) begin
          press_ticks_next = press_inc;
          if (press_inc > cfg.long_press_ticks) begin
            ev                 = bgc_pkg::EV_LONG_PRESS;
            release_ticks_next = '0;
            phase_next         = bgc_pkg::PH_LONG_WAIT;
          end
        end else begin
          release_ticks_next = '0;
          phase_next         = bgc_pkg::PH_CLICK_WAIT;
        end
      end
      bgc_pkg::PH_CLICK_WAIT: begin
        if (!key_down) begin
          // compare the count from before this tick
          release_ticks_next = release_inc;
          if (release_ticks > cfg.click_release_ticks) begin
            ev         = bgc_pkg::EV_CLICK;
            phase_next = bgc_pkg::PH_WAIT_RELEASE;
          end
        end else begin
          phase_next         = bgc_pkg::PH_SECOND_PRESS;
          press_ticks_next   = '0;
          release_ticks_next = '0;
        end
      end
      bgc_pkg::PH_SECOND_PRESS: begin
        if (key_down) begin
          press_ticks_next   = press_inc;
          release_ticks_next = '0;
          if (press_inc > cfg.debounce_ticks) phase_next = bgc_pkg::PH_SECOND_REL;
        end else begin
          press_ticks_next   = '0;
          release_ticks_next = release_inc;
          if (release_inc > cfg.release_quiet_ticks) phase_next = bgc_pkg::PH_WAIT_RELEASE;
        end
      end
      bgc_pkg::PH_SECOND_REL: begin
        // a press here leaves both timers alone
        if (!key_down) begin
          release_ticks_next = release_inc;
          if (release_inc > cfg.release_quiet_ticks) begin
            ev         = bgc_pkg::EV_DOUBLE_CLICK;
            phase_next = bgc_pkg::PH_WAIT_RELEASE;
          end
        end
      end
      bgc_pkg::PH_LONG_WAIT: begin
        if (!key_down) begin
          release_ticks_next = release_inc;
          if (release_inc > cfg.release_quiet_ticks) phase_next = bgc_pkg::PH_WAIT_RELEASE;
        end else begin
          press_ticks_next = press_inc;
          if (press_inc == cfg.hold_ticks) begin
            // hold only on the tick the count newly reaches the limit
            if (press_ticks != cfg.hold_ticks) ev = bgc_pkg::EV_HOLD;
          end else if (press_inc > cfg.reset_ticks) begin
            reset_request      = 1'b1;
            phase_next         = bgc_pkg::PH_WAIT_RELEASE;
            press_ticks_next   = '0;
            release_ticks_next = '0;
          end
        end
      end
      default: phase_next = bgc_pkg::PH_WAIT_RELEASE;
    endcase
    // display off forces idle and mutes the gesture, not the reset request
    if (!display_on) begin
      phase_next = bgc_pkg::PH_WAIT_RELEASE;
      ev         = bgc_pkg::EV_NONE;
    end
  end

  assign event_code = ev;

endmodule

### sv/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies button samples into click, double click, long press and hold.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, key_down, display_on  | sink
//  out     | out_valid, out_ready, event_code,         | source
//          | reset_request                             |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// one item per cycle sustained while out_ready is high; an item's result passes
// through the input register, then the result register.
// the state machine advances when an item moves from the input register
// into the result register, so each item sees the state left by the one before.
// a stalled result holds both registers; in_ready stays high whenever the
// input register is empty or moving on. reset restores the thresholds and
// returns to the wait-for-release phase with both timers cleared.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        key_down,
  input  logic                        display_on,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  event_code,
  output logic                        reset_request,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [bgc_pkg::TickW-1:0]   cfg_data
);

  bgc_pkg::cfg_t   cfg;
  logic            in_full;
  logic            in_key;
  logic            in_disp;
  logic            advance;
  bgc_pkg::event_t step_event;
  logic            step_reset;
  logic [2:0]      event_reg;
  logic            reset_reg;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  bgc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipeline flow
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_key  <= key_down;
      in_disp <= display_on;
    end
  end

  bgc_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .key_down      (in_key),
    .display_on    (in_disp),
    .cfg           (cfg),
    .event_code    (step_event),
    .reset_request (step_reset)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_reg <= step_event;
      reset_reg <= step_reset;
    end
  end

  assign event_code    = event_reg;
  assign reset_request = reset_reg;

endmodule
